/* hdl/bn_pkg.sv */
// Package for the batch normalization block: payload structs, formats, constants.
// Used by bn_front, bn_queue, bn_back, batch_norm_inference and the testbench; depends on nothing.
package bn_pkg;

   localparam int MaxChannels = 256;
   localparam int SampleWidth = 16;
   localparam int QueueDepth = 2;

   localparam logic [8:0] NumChannelsReset = 9'd1;
   localparam logic [15:0] EpsilonReset = 16'd66;

   typedef enum logic [0:0] {
      CSR_NUM_CHANNELS = 1'b0,
      CSR_EPSILON = 1'b1
   } csr_index_type;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_DATA = 1'b1;

   typedef struct packed {
      logic cmd;
      logic [7:0] load_channel;
      logic signed [15:0] gamma;
      logic signed [15:0] beta;
      logic signed [15:0] mean;
      logic [31:0] variance;
      logic signed [15:0] sample;
      logic frame_start;
   } req_type;

   typedef struct packed {
      logic signed [15:0] value;
      logic [7:0] out_channel;
      logic saturated;
   } rsp_type;

   // classified data word from front to back
   typedef struct packed {
      logic [7:0] channel;
      logic signed [15:0] sample;
   } data_word_type;

endpackage

/* hdl/bn_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end
   assign rd_data = rd_data_ff;
endmodule

/* hdl/bn_scale.sv */
// Iterative scale unit: scale = gamma * 2^24 / sqrt((var+eps)*2^16), rounded, saturated.
// No dependencies. One square root bit and one quotient bit per cycle.
module bn_scale (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic signed [15:0] gamma,
   input  logic [31:0] variance,
   input  logic [15:0] epsilon,
   output logic busy,
   output logic done,
   output logic [31:0] scale
);
   typedef enum logic [1:0] {S_IDLE, S_SQRT, S_DIV, S_DONE} state_type;

   state_type state_ff;
   logic [49:0] rad_ff;      // (var+eps)<<16, 49 bits used
   logic [49:0] rem_ff;
   logic [24:0] root_ff;
   logic [4:0] scnt_ff;
   logic [40:0] num_ff;      // dividend being shifted out
   logic [40:0] quo_ff;
   logic [25:0] drem_ff;
   logic [5:0] dcnt_ff;
   logic neg_ff;
   logic zero_ff;

   logic [49:0] trial;
   logic [49:0] rem_sh;
   logic [25:0] drem_sh;
   logic [40:0] lim;
   logic [40:0] qsat;
   logic [15:0] mag;

   always_comb begin
      mag = gamma[15] ? 16'(-gamma) : 16'(gamma);
      rem_sh = {rem_ff[47:0], rad_ff[49:48]};
      trial = {root_ff, 2'b01} + 50'd0;
      drem_sh = {drem_ff[24:0], num_ff[40]};
      lim = neg_ff ? 41'h0080000000 : 41'h007FFFFFFF;
      qsat = (root_ff == 25'd0 || quo_ff > lim) ? lim : quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  rad_ff <= 50'({33'(variance) + 33'(epsilon), 16'd0});
                  rem_ff <= '0;
                  root_ff <= '0;
                  scnt_ff <= 5'd25;
                  neg_ff <= gamma[15];
                  zero_ff <= (gamma == 16'sd0);
                  num_ff <= {1'b0, mag, 24'd0};
                  state_ff <= S_SQRT;
               end
            end
            S_SQRT: begin
               rad_ff <= {rad_ff[47:0], 2'b00};
               if (rem_sh >= trial) begin
                  rem_ff <= rem_sh - trial;
                  root_ff <= {root_ff[23:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  root_ff <= {root_ff[23:0], 1'b0};
               end
               scnt_ff <= scnt_ff - 5'd1;
               if (scnt_ff == 5'd1) begin
                  state_ff <= S_DIV;
                  dcnt_ff <= 6'd41;
                  quo_ff <= '0;
                  drem_ff <= '0;
               end
            end
            S_DIV: begin
               if (dcnt_ff == 6'd41) begin
                  // add root/2 for rounding to the dividend
                  num_ff <= num_ff + 41'(root_ff >> 1);
                  dcnt_ff <= 6'd40;
               end else begin
                  num_ff <= {num_ff[39:0], 1'b0};
                  if (drem_sh >= {1'b0, root_ff} && root_ff != 25'd0) begin
                     drem_ff <= drem_sh - {1'b0, root_ff};
                     quo_ff <= {quo_ff[39:0], 1'b1};
                  end else begin
                     drem_ff <= drem_sh;
                     quo_ff <= {quo_ff[39:0], 1'b0};
                  end
                  dcnt_ff <= dcnt_ff - 6'd1;
                  if (dcnt_ff == 6'd0) begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_DONE: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // last quotient bit lands at the final S_DIV cycle; quo_ff is complete in S_DONE
   always_comb begin
      scale = zero_ff ? 32'd0 : (neg_ff ? 32'(-qsat) : qsat[31:0]);
   end
   assign busy = (state_ff != S_IDLE);
   assign done = (state_ff == S_DONE);
endmodule

/* hdl/bn_front.sv */
// Front: accepts words, runs loads through the scale unit into the tables, assigns channels.
// Depends on bn_pkg and bn_scale.
module bn_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  bn_pkg::req_type req_data,
   input  logic [8:0] num_channels,
   input  logic [15:0] epsilon,
   input  logic q_full,
   input  logic q_empty,
   output logic q_push,
   output bn_pkg::data_word_type q_word,
   output logic tbl_wr,
   output logic [7:0] tbl_addr,
   output logic [31:0] tbl_scale,
   output logic [15:0] tbl_mean,
   output logic [15:0] tbl_beta
);
   logic [7:0] cnt_ff;
   logic [7:0] cnt_in;
   logic [7:0] ch;
   logic [7:0] ld_ch_ff;
   logic [15:0] ld_mean_ff;
   logic [15:0] ld_beta_ff;
   logic sc_busy;
   logic sc_done;
   logic sc_start;
   logic [31:0] sc_scale;
   logic acc;

   // a load waits until queued data words have read the tables
   assign req_ready = !sc_busy && ((req_data.cmd == bn_pkg::CMD_DATA) ? !q_full : q_empty);
   assign acc = req_valid && req_ready;
   assign sc_start = acc && req_data.cmd == bn_pkg::CMD_LOAD;

   always_comb begin
      ch = req_data.frame_start ? 8'd0 : cnt_ff;
      cnt_in = ({1'b0, ch} + 9'd1 == num_channels) ? 8'd0 : ch + 8'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (acc && req_data.cmd == bn_pkg::CMD_DATA) begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sc_start) begin
         ld_ch_ff <= req_data.load_channel;
         ld_mean_ff <= req_data.mean;
         ld_beta_ff <= req_data.beta;
      end
   end

   bn_scale u_scale (
      .clock(clock), .reset(reset), .start(sc_start), .gamma(req_data.gamma),
      .variance(req_data.variance), .epsilon(epsilon), .busy(sc_busy),
      .done(sc_done), .scale(sc_scale)
   );

   assign q_push = acc && req_data.cmd == bn_pkg::CMD_DATA;
   assign q_word = '{channel: ch, sample: req_data.sample};
   assign tbl_wr = sc_done;
   assign tbl_addr = ld_ch_ff;
   assign tbl_scale = sc_scale;
   assign tbl_mean = ld_mean_ff;
   assign tbl_beta = ld_beta_ff;
endmodule

/* hdl/bn_queue.sv */
// Short FIFO of classified data words between front and back.
// Depends on bn_pkg.
module bn_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  bn_pkg::data_word_type push_word,
   output logic full,
   input  logic pop,
   output logic empty,
   output bn_pkg::data_word_type head
);
   localparam int D = bn_pkg::QueueDepth;
   bn_pkg::data_word_type buf_ff [D];
   logic [$clog2(D)-1:0] rd_ff;
   logic [$clog2(D)-1:0] wr_ff;
   logic [$clog2(D):0] cnt_ff;

   assign full = (cnt_ff == ($clog2(D)+1)'(D));
   assign empty = (cnt_ff == '0);
   assign head = buf_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
         wr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
      end
   end
   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ff] <= push_word;
      end
   end
endmodule

/* hdl/bn_back.sv */
// Back: reads channel tables, subtracts mean, multiplies, rounds, adds offset, saturates, holds result.
// Depends on bn_pkg and bn_ram.
module bn_back (
   input  logic clock,
   input  logic reset,
   input  logic tbl_wr,
   input  logic [7:0] tbl_addr,
   input  logic [31:0] tbl_scale,
   input  logic [15:0] tbl_mean,
   input  logic [15:0] tbl_beta,
   input  logic q_empty,
   input  bn_pkg::data_word_type q_head,
   output logic q_pop,
   output logic rsp_valid,
   input  logic rsp_ready,
   output bn_pkg::rsp_type rsp_data
);
   localparam int AW = (bn_pkg::MaxChannels > 1) ? $clog2(bn_pkg::MaxChannels) : 1;
   localparam logic signed [48:0] Hi = 49'sd2 ** (bn_pkg::SampleWidth - 1) - 49'sd1;
   localparam logic signed [48:0] Lo = -Hi - 49'sd1;

   logic s1_ff, s2_ff, s3_ff;
   logic [7:0] ch1_ff, ch2_ff, ch3_ff;
   logic signed [15:0] smp1_ff;
   logic signed [16:0] d_ff;
   logic signed [48:0] p_ff;
   logic signed [15:0] beta2_ff, beta3_ff;
   logic [31:0] scale_rd;
   logic [15:0] mean_rd;
   logic [15:0] beta_rd;
   logic [31:0] scale2_ff;
   logic adv;
   logic out_v_ff;
   bn_pkg::rsp_type out_ff;
   logic signed [48:0] r;
   logic [AW-1:0] wa, ra;

   // pipeline advances when the output register is free or being drained
   assign adv = !out_v_ff || rsp_ready;
   assign q_pop = adv && !q_empty;
   assign wa = AW'(tbl_addr % bn_pkg::MaxChannels);
   assign ra = AW'(q_head.channel % bn_pkg::MaxChannels);

   bn_ram #(.WIDTH(32), .DEPTH(bn_pkg::MaxChannels)) u_scale_ram (
      .clock(clock), .wr_en(tbl_wr), .wr_addr(wa), .wr_data(tbl_scale),
      .rd_en(adv), .rd_addr(ra), .rd_data(scale_rd)
   );
   bn_ram #(.WIDTH(16), .DEPTH(bn_pkg::MaxChannels)) u_mean_ram (
      .clock(clock), .wr_en(tbl_wr), .wr_addr(wa), .wr_data(tbl_mean),
      .rd_en(adv), .rd_addr(ra), .rd_data(mean_rd)
   );
   bn_ram #(.WIDTH(16), .DEPTH(bn_pkg::MaxChannels)) u_beta_ram (
      .clock(clock), .wr_en(tbl_wr), .wr_addr(wa), .wr_data(tbl_beta),
      .rd_en(adv), .rd_addr(ra), .rd_data(beta_rd)
   );

   always_comb begin
      r = (p_ff + 49'sd32768) >>> 16;
      r = r + 49'(beta3_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
         s3_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (adv) begin
            s1_ff <= !q_empty;
            s2_ff <= s1_ff;
            s3_ff <= s2_ff;
            out_v_ff <= s3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ch1_ff <= q_head.channel;
         smp1_ff <= q_head.sample;
         ch2_ff <= ch1_ff;
         d_ff <= 17'(smp1_ff) - 17'($signed(mean_rd));
         scale2_ff <= scale_rd;
         beta2_ff <= $signed(beta_rd);
         ch3_ff <= ch2_ff;
         p_ff <= 49'(d_ff) * 49'($signed(scale2_ff));
         beta3_ff <= beta2_ff;
         out_ff.out_channel <= ch3_ff;
         if (r > Hi) begin
            out_ff.value <= Hi[15:0];
            out_ff.saturated <= 1'b1;
         end else if (r < Lo) begin
            out_ff.value <= Lo[15:0];
            out_ff.saturated <= 1'b1;
         end else begin
            out_ff.value <= r[15:0];
            out_ff.saturated <= 1'b0;
         end
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data = out_ff;
endmodule

/* hdl/batch_norm_inference.sv */
// Batch normalization at inference. Data words: one per cycle while no load runs and the
// queue has room; each passes the queue, s1_ff, s2_ff, s3_ff, out_ff. Loads use the bit-serial
// square root and divider, blocking all words; a load is accepted only once the queue is empty.
// Reset (synchronous) clears the channel counter, queue and pipeline valids; tables are
// undefined until loaded. Registers reset to num_channels 1, epsilon 66.
module batch_norm_inference (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  bn_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output bn_pkg::rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [0:0] csr_index,
   input  logic [15:0] csr_data
);
   logic [8:0] num_ch_ff;
   logic [15:0] eps_ff;
   logic q_full, q_empty, q_push, q_pop;
   bn_pkg::data_word_type q_word, q_head;
   logic tbl_wr;
   logic [7:0] tbl_addr;
   logic [31:0] tbl_scale;
   logic [15:0] tbl_mean, tbl_beta;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         num_ch_ff <= bn_pkg::NumChannelsReset;
         eps_ff <= bn_pkg::EpsilonReset;
      end else if (csr_valid) begin
         case (bn_pkg::csr_index_type'(csr_index))
            bn_pkg::CSR_NUM_CHANNELS: num_ch_ff <= csr_data[8:0];
            bn_pkg::CSR_EPSILON: eps_ff <= csr_data;
            default: ;
         endcase
      end
   end

   bn_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_data(req_data), .num_channels(num_ch_ff), .epsilon(eps_ff),
      .q_full(q_full), .q_empty(q_empty), .q_push(q_push), .q_word(q_word),
      .tbl_wr(tbl_wr), .tbl_addr(tbl_addr), .tbl_scale(tbl_scale), .tbl_mean(tbl_mean),
      .tbl_beta(tbl_beta)
   );
   bn_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_word(q_word), .full(q_full),
      .pop(q_pop), .empty(q_empty), .head(q_head)
   );
   bn_back u_back (
      .clock(clock), .reset(reset), .tbl_wr(tbl_wr), .tbl_addr(tbl_addr),
      .tbl_scale(tbl_scale), .tbl_mean(tbl_mean), .tbl_beta(tbl_beta),
      .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop), .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );
endmodule

/* sim/tb_batch_norm_inference.sv */
// Testbench for batch_norm_inference: random and directed load/data words with
// prediction in a small scoreboard class. Depends on hdl/bn_pkg.sv and the RTL.
module tb_batch_norm_inference;
   timeunit 1ns;
   timeprecision 1ps;

   class bn_scoreboard;
      logic [31:0] scale_mem [256];
      logic signed [15:0] mean_mem [256];
      logic signed [15:0] beta_mem [256];
      logic [7:0] chan_count;
      logic [8:0] num_chan;
      logic [15:0] eps;
      bn_pkg::rsp_type pending [$];
      int errors;

      function new();
         chan_count = 0;
         num_chan = bn_pkg::NumChannelsReset;
         eps = bn_pkg::EpsilonReset;
         errors = 0;
      endfunction

      function void write_reg(bn_pkg::csr_index_type idx, logic [15:0] val);
         if (idx == bn_pkg::CSR_NUM_CHANNELS) num_chan = val[8:0];
         else eps = val;
      endfunction

      function logic [31:0] scale_of(logic signed [15:0] g, logic [31:0] vr);
         longint unsigned x, r, b, mag, lim, q;
         longint gi;
         x = (longint'(vr) + longint'(eps)) << 16;
         r = 0;
         b = 64'd1 << 62;
         while (b > x) b >>= 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x -= r + b;
               r = (r >> 1) + b;
            end else r >>= 1;
            b >>= 2;
         end
         gi = g;
         mag = (gi < 0) ? -gi : gi;
         lim = (gi < 0) ? 64'h8000_0000 : 64'h7FFF_FFFF;
         if (mag == 0) return 32'd0;
         if (r == 0) q = lim;
         else begin
            q = ((mag << 24) + (r >> 1)) / r;
            if (q > lim) q = lim;
         end
         return (gi < 0) ? 32'(-q) : 32'(q);
      endfunction

      function void note(bn_pkg::req_type w);
         bn_pkg::rsp_type e;
         logic [7:0] ch;
         longint d, p, t, hi, lo;
         if (w.cmd == bn_pkg::CMD_LOAD) begin
            scale_mem[w.load_channel] = scale_of(w.gamma, w.variance);
            beta_mem[w.load_channel] = w.beta;
            mean_mem[w.load_channel] = w.mean;
            return;
         end
         ch = w.frame_start ? 8'd0 : chan_count;
         chan_count = (int'(ch) + 1 == int'(num_chan)) ? 8'd0 : ch + 8'd1;
         d = longint'(w.sample) - longint'(mean_mem[ch]);
         p = d * longint'($signed(scale_mem[ch]));
         t = ((p + 32768) >>> 16) + longint'(beta_mem[ch]);
         hi = 32767;
         lo = -32768;
         e.saturated = (t > hi) || (t < lo);
         if (t > hi) t = hi;
         if (t < lo) t = lo;
         e.value = 16'(t);
         e.out_channel = ch;
         pending.push_back(e);
      endfunction

      function void check(bn_pkg::rsp_type a);
         bn_pkg::rsp_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word %p", a);
            return;
         end
         e = pending.pop_front();
         if (a.value !== e.value || a.out_channel !== e.out_channel
             || a.saturated !== e.saturated) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p actual %p", e, a);
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready, csr_valid, csr_ready;
   bn_pkg::req_type req_data;
   bn_pkg::rsp_type rsp_data;
   logic [0:0] csr_index;
   logic [15:0] csr_data;
   int tx_idle = 0;
   int rx_idle = 0;
   int quiet = 0;
   bn_scoreboard sb = new();

   batch_norm_inference i_dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_idle);
      if (!reset) begin
         if (req_valid && req_ready) sb.note(req_data);
         if (rsp_valid && rsp_ready) sb.check(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet <= 0;
         else quiet <= quiet + 1;
         if (quiet > 20000) begin
            $display("FAIL batch_norm_inference");
            $finish;
         end
      end
   end

   task automatic send(bn_pkg::req_type w);
      if ($urandom_range(99) < tx_idle) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle);
      end
      req_valid <= 1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_csr(bn_pkg::csr_index_type idx, logic [15:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      csr_valid <= 0;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic bn_pkg::req_type load_word(logic [7:0] ch, logic signed [15:0] g,
                                                 logic signed [15:0] b,
                                                 logic signed [15:0] m, logic [31:0] vr);
      bn_pkg::req_type w;
      w = bn_pkg::req_type'(106'({$urandom, $urandom, $urandom, $urandom}));
      w.cmd = bn_pkg::CMD_LOAD;
      w.load_channel = ch;
      w.gamma = g;
      w.beta = b;
      w.mean = m;
      w.variance = vr;
      return w;
   endfunction

   function automatic bn_pkg::req_type data_word(logic signed [15:0] s, logic fs);
      bn_pkg::req_type w;
      w = bn_pkg::req_type'(106'({$urandom, $urandom, $urandom, $urandom}));
      w.cmd = bn_pkg::CMD_DATA;
      w.sample = s;
      w.frame_start = fs;
      return w;
   endfunction

   function automatic bn_pkg::req_type random_word();
      logic [31:0] vr;
      case ($urandom_range(2))
         0: vr = $urandom_range(255);
         1: vr = $urandom_range(1 << 20);
         default: vr = $urandom;
      endcase
      if ($urandom_range(9) == 0)
         return load_word(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), vr);
      return data_word(16'($urandom), $urandom_range(7) == 0);
   endfunction

   int nc_set [6] = '{4, 256, 1, 0, 300, 3};
   int eps_set [6] = '{0, 65535, 66, 1000, 0, 12345};

   initial begin
      reset <= 1;
      req_valid <= 0;
      req_data <= '0;
      csr_valid <= 0;
      csr_index <= bn_pkg::CSR_NUM_CHANNELS;
      csr_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 0;
      write_csr(bn_pkg::CSR_EPSILON, 16'd0);
      write_csr(bn_pkg::CSR_NUM_CHANNELS, 16'd4);
      for (int c = 0; c < 256; c++)
         send(load_word(8'(c), 16'($urandom), 16'($urandom), 16'($urandom),
                        $urandom_range(1 << 18)));
      // zero root with each gamma sign, widest variance, extreme offsets
      send(load_word(8'd0, 16'sh7FFF, 16'sh0000, 16'sh0000, 32'd0));
      send(load_word(8'd1, 16'sh8000, 16'sh7FFF, 16'sh8000, 32'd0));
      send(load_word(8'd2, 16'sh0000, 16'sh8000, 16'sh7FFF, 32'd0));
      send(load_word(8'd3, 16'sh0001, 16'sh8000, 16'sh7FFF, 32'hFFFF_FFFF));
      send(data_word(16'sh7FFF, 1));
      send(data_word(16'sh8000, 0));
      send(data_word(16'sh0000, 0));
      send(data_word(16'sh8000, 0));
      send(data_word(16'sh0001, 0));
      send(data_word(16'sh8000, 0));
      send(data_word(16'sh7FFF, 0));
      send(data_word(16'sh7FFF, 0));
      send(data_word(16'sh8000, 1));
      send(data_word(16'sh7FFF, 0));
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(bn_pkg::CSR_NUM_CHANNELS, 16'(nc_set[ph]));
         write_csr(bn_pkg::CSR_EPSILON, 16'(eps_set[ph]));
         tx_idle = (ph % 3 == 0) ? 15 : (ph % 3 == 1) ? 85 : 0;
         rx_idle = (ph % 3 == 0) ? 85 : (ph % 3 == 1) ? 15 : 0;
         for (int n = 0; n < 290; n++) send(random_word());
         drain();
      end
      if (sb.errors == 0 && sb.pending.size() == 0) $display("PASS batch_norm_inference");
      else $display("FAIL batch_norm_inference");
      $finish;
   end
endmodule
